@@ rtl/core/two_level_page_walker_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page walker checker
// Clocked property wrappers with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_WALKER_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALKER_DEFINES_SVH

// Property checked only outside reset.
`define TLPW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define TLPW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tlpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared codes and payload types of the two-level page walker.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int FRAME_SHIFT = 12;
  localparam int DIR_SHIFT   = 22;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGING_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTORY_BASE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_OFFSET  = 2'd2;

  // input commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ENTRY     = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_FAULT   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // fault codes
  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OFF    = 2'd1;
  localparam logic [1:0] FAULT_ABSENT = 2'd2;
  localparam logic [1:0] FAULT_WRPROT = 2'd3;

  // entry bit positions
  localparam int PTE_PRESENT = 0;
  localparam int PTE_WRITE   = 1;
  localparam int PTE_USER    = 2;

  typedef struct packed {
    logic              paging_enabled;
    logic [ADDR_W-1:0] directory_base;
    logic [ADDR_W-1:0] memory_offset;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] virtual_address;
    logic              is_write;
    logic [ADDR_W-1:0] entry_word;
  } item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] physical_address;
    logic              writable;
    logic              user_ok;
    logic [1:0]        fault_code;
  } result_t;

endpackage

@@ rtl/core/tlpw_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_cfg_regs
// Configuration register file: paging enable, directory base, memory offset.
// ----------------------------------------------------------------------------
module tlpw_cfg_regs
  import tlpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGING_ENABLED: cfg.paging_enabled <= cfg_data[0];
        CFG_DIRECTORY_BASE: cfg.directory_base <= cfg_data;
        CFG_MEMORY_OFFSET:  cfg.memory_offset  <= cfg_data;
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

endmodule

@@ rtl/core/tlpw_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_in_reg
// Input register: holds one request until the walk logic takes it.
// ----------------------------------------------------------------------------
module tlpw_in_reg
  import tlpw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  // free when empty, or when the held request leaves this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

@@ rtl/core/tlpw_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_walk
// Walk state and the single-pass step logic for one request.
// ----------------------------------------------------------------------------
module tlpw_walk
  import tlpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    advance,
  output result_t res
);

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_DIR   = 2'd1;
  localparam logic [1:0] PHASE_TABLE = 2'd2;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [ADDR_W-1:0] held_address;
  logic [ADDR_W-1:0] held_address_next;
  logic              held_write;
  logic              held_write_next;
  logic              busy;
  logic [ADDR_W-1:0] frame_base;

  // unused phase code reads as idle
  always_comb begin
    unique case (phase)
      PHASE_DIR, PHASE_TABLE: busy = 1'b1;
      default:                busy = 1'b0;
    endcase
  end

  assign frame_base = {item.entry_word[ADDR_W-1:FRAME_SHIFT], {FRAME_SHIFT{1'b0}}};

  always_comb begin
    res               = '0;
    phase_next        = phase;
    held_address_next = held_address;
    held_write_next   = held_write;
    if (item.command == CMD_TRANSLATE) begin
      if (busy) begin
        res.result_kind = KIND_IGNORED;
      end else if (!cfg.paging_enabled) begin
        res.result_kind = KIND_FAULT;
        res.fault_code  = FAULT_OFF;
        phase_next      = PHASE_IDLE;
      end else begin
        held_address_next = item.virtual_address;
        held_write_next   = item.is_write;
        phase_next        = PHASE_DIR;
        res.result_kind   = KIND_READ;
        res.read_address  = cfg.directory_base +
          {{(DIR_SHIFT-2){1'b0}}, item.virtual_address[ADDR_W-1:DIR_SHIFT], 2'b00};
      end
    end else if (!busy) begin
      res.result_kind = KIND_IGNORED;
      phase_next      = PHASE_IDLE;
    end else if (!item.entry_word[PTE_PRESENT]) begin
      res.result_kind = KIND_FAULT;
      res.fault_code  = FAULT_ABSENT;
      phase_next      = PHASE_IDLE;
    end else if (phase == PHASE_DIR) begin
      phase_next       = PHASE_TABLE;
      res.result_kind  = KIND_READ;
      res.read_address = frame_base + cfg.memory_offset +
        {{(ADDR_W-(DIR_SHIFT-FRAME_SHIFT)-2){1'b0}},
         held_address[DIR_SHIFT-1:FRAME_SHIFT], 2'b00};
    end else begin
      phase_next = PHASE_IDLE;
      if (held_write && !item.entry_word[PTE_WRITE]) begin
        res.result_kind = KIND_FAULT;
        res.fault_code  = FAULT_WRPROT;
      end else begin
        res.result_kind      = KIND_DONE;
        res.physical_address = {item.entry_word[ADDR_W-1:FRAME_SHIFT],
                                held_address[FRAME_SHIFT-1:0]};
        res.writable         = item.entry_word[PTE_WRITE];
        res.user_ok          = item.entry_word[PTE_USER];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_IDLE;
      held_address <= '0;
      held_write   <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      held_address <= held_address_next;
      held_write   <= held_write_next;
    end
  end

endmodule

@@ rtl/core/tlpw_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module tlpw_out_reg
  import tlpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ rtl/core/two_level_page_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walker
// Two-level i386-style page table walker: requests in, read requests,
// translations and faults out.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_ready   | command, virtual_address, is_write,
//          |                       | entry_word
//  out     | out_valid / out_ready | result_kind, read_address,
//          |                       | physical_address, writable, user_ok,
//          |                       | fault_code
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Each request gives exactly one result via the input and result registers;
//  one request per cycle is sustained while the result side is not stalled.
//  The walk step is a single pass of compare and one three-input add between
//  the input register and the result register.
//  Reset (rst, synchronous) empties both registers and returns the walk to
//  idle with cleared configuration; cfg_ready is always high.
//  A stalled result holds the result register; the input register still
//  takes one more request, after which in_ready drops.
// ----------------------------------------------------------------------------
module two_level_page_walker
  import tlpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [ADDR_W-1:0]      virtual_address,
  input  logic                   is_write,
  input  logic [ADDR_W-1:0]      entry_word,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             result_kind,
  output logic [ADDR_W-1:0]      read_address,
  output logic [ADDR_W-1:0]      physical_address,
  output logic                   writable,
  output logic                   user_ok,
  output logic [1:0]             fault_code,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t step_res;
  result_t out_res;

  // pack the request fields for the input register
  assign in_item = '{command:         command,
                     virtual_address: virtual_address,
                     is_write:        is_write,
                     entry_word:      entry_word};

  // advance the held request when the result register is free or draining
  assign advance = held_valid && (!out_valid || out_ready);

  tlpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlpw_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // walk state changes only when a request actually moves to the result side
  tlpw_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (held_item),
    .advance (advance),
    .res     (step_res)
  );

  tlpw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  // unpack the result onto the output ports
  assign result_kind      = out_res.result_kind;
  assign read_address     = out_res.read_address;
  assign physical_address = out_res.physical_address;
  assign writable         = out_res.writable;
  assign user_ok          = out_res.user_ok;
  assign fault_code       = out_res.fault_code;

endmodule

@@ rtl/core/tlpw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_checker
// Port-level checks on the page walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_level_page_walker_defines.svh"

module tlpw_checker
  import tlpw_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             result_kind,
  input logic [ADDR_W-1:0]      read_address,
  input logic [ADDR_W-1:0]      physical_address,
  input logic                   writable,
  input logic                   user_ok,
  input logic [1:0]             fault_code
);

  `TLPW_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result pending after reset")

  `TLPW_ASSERT(a_stall_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(result_kind) && $stable(read_address) && $stable(physical_address) && $stable(fault_code)), "stalled result changed")

  `TLPW_ASSERT(a_ready_only_on_stall, clk, rst, !in_ready |-> (out_valid && !out_ready), "request refused without output stall")

  `TLPW_ASSERT(a_fault_fields, clk, rst, (out_valid && result_kind == KIND_FAULT) |-> (fault_code != FAULT_NONE && read_address == '0 && physical_address == '0), "fault result carries stray fields")

  `TLPW_ASSERT(a_read_fields, clk, rst, (out_valid && result_kind == KIND_READ) |-> (fault_code == FAULT_NONE && physical_address == '0 && !writable && !user_ok), "read request carries stray fields")

endmodule

bind two_level_page_walker tlpw_checker u_checker (.*);

@@ test/two_level_page_walker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walker_tb
// Self-checking bench for the two-level page walker. Drives translate
// requests and returned entry words, predicts every result in step with the
// walker's own phase, and compares each delivered result field by field.
// Covers directed corner walks, then phases of random walks under several
// register settings with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module two_level_page_walker_tb;
  import tlpw_pkg::*;

  // Phase of the walk as the predictor tracks it
  typedef enum logic [1:0] {
    WALK_IDLE  = 2'd0,
    WALK_DIR   = 2'd1,
    WALK_TABLE = 2'd2
  } walk_phase_t;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int LONG_HOLD       = 100;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: a copy of the walker state and registers, plus the queue of
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class walk_scoreboard;
    cfg_t        regs;
    walk_phase_t phase;
    logic [31:0] held_va;
    logic        held_wr;
    result_t     owed_results[$];
    int          mismatches;
    int          checked;
    int          kind_count[4];
    int          fault_count[4];

    function new();
      regs       = '0;
      phase      = WALK_IDLE;
      held_va    = '0;
      held_wr    = 1'b0;
      mismatches = 0;
      checked    = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
      foreach (fault_count[i]) fault_count[i] = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_PAGING_ENABLED: regs.paging_enabled = data[0];
        CFG_DIRECTORY_BASE: regs.directory_base = data;
        CFG_MEMORY_OFFSET:  regs.memory_offset  = data;
        default: ;
      endcase
    endfunction

    // One walk step: update the state and return the result it gives
    function result_t walk_step(item_t it);
      result_t r;
      logic    busy;
      r    = '0;
      busy = (phase == WALK_DIR) || (phase == WALK_TABLE);
      if (it.command == CMD_TRANSLATE) begin
        if (busy) begin
          r.result_kind = KIND_IGNORED;
        end else if (!regs.paging_enabled) begin
          phase         = WALK_IDLE;
          r.result_kind = KIND_FAULT;
          r.fault_code  = FAULT_OFF;
        end else begin
          held_va        = it.virtual_address;
          held_wr        = it.is_write;
          phase          = WALK_DIR;
          r.result_kind  = KIND_READ;
          r.read_address = regs.directory_base +
                           {20'd0, it.virtual_address[31:22], 2'b00};
        end
      end else if (!busy) begin
        phase         = WALK_IDLE;
        r.result_kind = KIND_IGNORED;
      end else if (!it.entry_word[PTE_PRESENT]) begin
        phase         = WALK_IDLE;
        r.result_kind = KIND_FAULT;
        r.fault_code  = FAULT_ABSENT;
      end else if (phase == WALK_DIR) begin
        phase          = WALK_TABLE;
        r.result_kind  = KIND_READ;
        r.read_address = {it.entry_word[31:12], 12'd0} + regs.memory_offset +
                         {20'd0, held_va[21:12], 2'b00};
      end else begin
        phase = WALK_IDLE;
        if (held_wr && !it.entry_word[PTE_WRITE]) begin
          r.result_kind = KIND_FAULT;
          r.fault_code  = FAULT_WRPROT;
        end else begin
          r.result_kind      = KIND_DONE;
          r.physical_address = {it.entry_word[31:12], held_va[11:0]};
          r.writable         = it.entry_word[PTE_WRITE];
          r.user_ok          = it.entry_word[PTE_USER];
        end
      end
      return r;
    endfunction

    function void note_request(item_t it);
      owed_results.push_back(walk_step(it));
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing owed: kind=%0d rd=%h pa=%h w=%b u=%b fc=%0d",
                   $time, got.result_kind, got.read_address, got.physical_address,
                   got.writable, got.user_ok, got.fault_code);
        return;
      end
      exp_r = owed_results.pop_front();
      checked++;
      kind_count[exp_r.result_kind]++;
      if (exp_r.result_kind == KIND_FAULT) fault_count[exp_r.fault_code]++;
      if (got.result_kind      !== exp_r.result_kind      ||
          got.read_address     !== exp_r.read_address     ||
          got.physical_address !== exp_r.physical_address ||
          got.writable         !== exp_r.writable         ||
          got.user_ok          !== exp_r.user_ok          ||
          got.fault_code       !== exp_r.fault_code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch, expected kind=%0d rd=%h pa=%h w=%b u=%b fc=%0d",
                   $time, exp_r.result_kind, exp_r.read_address,
                   exp_r.physical_address, exp_r.writable, exp_r.user_ok,
                   exp_r.fault_code);
          $display("%0t:           got      kind=%0d rd=%h pa=%h w=%b u=%b fc=%0d",
                   $time, got.result_kind, got.read_address, got.physical_address,
                   got.writable, got.user_ok, got.fault_code);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input starts known.
  // --------------------------------------------------------------------------
  logic                   clk             = 1'b0;
  logic                   rst             = 1'b1;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic                   command         = CMD_TRANSLATE;
  logic [ADDR_W-1:0]      virtual_address = '0;
  logic                   is_write        = 1'b0;
  logic [ADDR_W-1:0]      entry_word      = '0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [1:0]             result_kind;
  logic [ADDR_W-1:0]      read_address;
  logic [ADDR_W-1:0]      physical_address;
  logic                   writable;
  logic                   user_ok;
  logic [1:0]             fault_code;
  logic                   cfg_valid       = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index       = CFG_PAGING_ENABLED;
  logic [ADDR_W-1:0]      cfg_data        = '0;

  walk_scoreboard sb = new();

  // Long result-side hold: the stimulus asks, the receiver serves
  int hold_asked  = 0;
  int hold_served = 0;

  always #5 clk = ~clk;

  two_level_page_walker dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .virtual_address  (virtual_address),
    .is_write         (is_write),
    .entry_word       (entry_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .read_address     (read_address),
    .physical_address (physical_address),
    .writable         (writable),
    .user_ok          (user_ok),
    .fault_code       (fault_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Request builders. Fields the command does not use carry random bits so
  // that they are shown to be ignored.
  // --------------------------------------------------------------------------
  function automatic item_t make_translate(logic [31:0] va, logic wr);
    item_t it;
    it.command         = CMD_TRANSLATE;
    it.virtual_address = va;
    it.is_write        = wr;
    it.entry_word      = $urandom();
    return it;
  endfunction

  function automatic item_t make_entry(logic [31:0] word);
    item_t it;
    it.command         = CMD_ENTRY;
    it.virtual_address = $urandom();
    it.is_write        = 1'($urandom_range(0, 1));
    it.entry_word      = word;
    return it;
  endfunction

  // Mostly well-formed walks that follow the predicted phase; one in ten
  // requests is noise (requests while busy, stray entry words).
  function automatic item_t next_item();
    item_t       it;
    logic [31:0] va;
    logic [31:0] word;
    va   = $urandom();
    word = $urandom();
    case ($urandom_range(0, 15))
      0: va = '0;
      1: va = '1;
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0: word[31:12] = '0;
      1: word[31:12] = '1;
      default: ;
    endcase
    // present in most entries, so most walks reach the table
    word[PTE_PRESENT] = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 9) == 0) begin
      it.command         = 1'($urandom_range(0, 1));
      it.virtual_address = va;
      it.is_write        = 1'($urandom_range(0, 1));
      it.entry_word      = $urandom();
    end else if (sb.phase == WALK_IDLE) begin
      it = make_translate(va, 1'($urandom_range(0, 1)));
    end else begin
      it = make_entry(word);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Everything is driven by nonblocking assignment just after a
  // rising edge; acceptance is judged on the values seen at the edge.
  // --------------------------------------------------------------------------

  // Offer one request and hold it until accepted; valid stays high after.
  task automatic send_request(input item_t it);
    in_valid        <= 1'b1;
    command         <= it.command;
    virtual_address <= it.virtual_address;
    is_write        <= it.is_write;
    entry_word      <= it.entry_word;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  // Drop valid for a gap, with junk on the payload meanwhile.
  task automatic idle_gap(input int cycles);
    in_valid        <= 1'b0;
    virtual_address <= $urandom();
    entry_word      <= $urandom();
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has been delivered, then
  // let the pipeline drain a little further.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic pe, input logic [31:0] base,
                              input logic [31:0] offset);
    logic [31:0] upper;
    upper = $urandom();
    // upper bits of the paging word must be ignored
    write_reg(CFG_PAGING_ENABLED, {upper[31:1], pe});
    write_reg(CFG_DIRECTORY_BASE, base);
    write_reg(CFG_MEMORY_OFFSET, offset);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: accept in changing patterns; serve a long hold on request.
  // --------------------------------------------------------------------------
  initial begin
    int rx_mode;
    int rx_cycle;
    int hold_left;
    rx_mode   = 0;
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 250 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((rx_cycle % 7) < 4);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check every delivered result against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({result_kind, read_address, physical_address,
                       writable, user_ok, fault_code});
  end

  // Watchdog: end the run if nothing at all moves for too long
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t with %0d results owed", $time, sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          sent;
    int          burst;
    int          total;
    logic        hold_done;
    logic        pe;
    logic [31:0] base;
    logic [31:0] offset;

    total     = 0;
    hold_done = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Paging is off after reset: a request faults, a stray entry is ignored
    send_request(make_translate(32'h1234_5678, 1'b0));
    send_request(make_entry(32'hffff_ffff));
    settle();
    program_regs(1'b1, 32'h0000_0000, 32'h0000_0000);

    // Lowest and highest addresses and entries, full walks
    send_request(make_translate(32'h0000_0000, 1'b0));
    send_request(make_entry(32'h0000_0001));
    send_request(make_entry(32'h0000_0007));
    send_request(make_translate(32'hffff_ffff, 1'b1));
    send_request(make_entry(32'hffff_ffff));
    send_request(make_entry(32'hffff_ffff));
    // Write to a read-only page
    send_request(make_translate(32'h0040_1abc, 1'b1));
    send_request(make_entry(32'h0000_3001));
    send_request(make_entry(32'h0000_5005));
    // Directory entry not present
    send_request(make_translate(32'h8000_0000, 1'b0));
    send_request(make_entry(32'hffff_fffe));
    // Table entry not present
    send_request(make_translate(32'h7fff_f000, 1'b1));
    send_request(make_entry(32'h0012_3003));
    send_request(make_entry(32'hffff_fffe));
    // New request while a walk is busy at each level; the walk goes on
    send_request(make_translate(32'h0123_4567, 1'b0));
    send_request(make_translate(32'h89ab_cdef, 1'b1));
    send_request(make_entry(32'h0abc_d001));
    send_request(make_translate(32'hfedc_ba98, 1'b1));
    send_request(make_entry(32'h0fed_c005));
    // Paging switched off in the middle of a walk: the walk still finishes
    send_request(make_translate(32'h00c0_0fff, 1'b1));
    send_request(make_entry(32'h0000_1001));
    settle();
    write_reg(CFG_PAGING_ENABLED, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_request(make_entry(32'h0002_0003));
    send_request(make_translate(32'h0000_1000, 1'b0));
    total = 25;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      pe     = (ph == 2) ? 1'b0 : (ph == 5) ? logic'($urandom_range(0, 1)) : 1'b1;
      base   = $urandom() & 32'hffff_f000;
      offset = $urandom();
      case (ph)
        0: begin
          base   = '0;
          offset = '0;
        end
        1: begin
          base   = '1;
          offset = '1;
        end
        6: base = $urandom();
        default: ;
      endcase
      program_regs(pe, base, offset);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 30);
        // Once: stall the result side for a long stretch while requests keep
        // coming, so the block fills up and holds off its input
        if (ph == 4 && !hold_done && sent >= 40) begin
          hold_done = 1'b1;
          hold_asked++;
          burst = 24;
        end
        // keep each phase at its share of requests
        if (burst > ITEMS_PER_PHASE - sent) burst = ITEMS_PER_PHASE - sent;
        repeat (burst) begin
          send_request(next_item());
          sent++;
        end
        // a quarter of the bursts run straight into the next
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      total += sent;
    end

    settle();
    repeat (8) @(posedge clk);

    $display("ran %0d requests over %0d register settings, %0d results checked",
             total, NUM_PHASES + 2, sb.checked);
    $display("reads %0d, done %0d, faults off/absent/wrprot %0d/%0d/%0d, ignored %0d",
             sb.kind_count[KIND_READ], sb.kind_count[KIND_DONE],
             sb.fault_count[FAULT_OFF], sb.fault_count[FAULT_ABSENT],
             sb.fault_count[FAULT_WRPROT], sb.kind_count[KIND_IGNORED]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results still owed", sb.mismatches, sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tlpw_pkg.sv
rtl/core/tlpw_cfg_regs.sv
rtl/core/tlpw_in_reg.sv
rtl/core/tlpw_walk.sv
rtl/core/tlpw_out_reg.sv
rtl/core/two_level_page_walker.sv
rtl/core/tlpw_checker.sv
test/two_level_page_walker_tb.sv
